>>> rtl/core/sobel_edge_magnitude_rgb_core_macros.svh
// ----------------------------------------------------------------------------
// Sobel core assertion macros
// Shared concurrent assertion helpers for the Sobel edge core.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel core package
// Shared types, constants and helpers of the Sobel edge core.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned PixW  = 24;
  localparam int unsigned RowW  = 16;
  localparam int unsigned ColW  = 10;
  localparam int unsigned WCfgW = 11;
  localparam int unsigned HCfgW = 16;
  localparam int unsigned CfgDW = 16;
  localparam int unsigned CfgAW = 1;

  // Configuration register indexes
  localparam logic [CfgAW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgAW-1:0] RegHeight = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCalc,
    StRoot,
    StOut
  } seq_state_e;

  // Result beat
  typedef struct packed {
    logic [7:0]      red_out;
    logic [7:0]      green_out;
    logic [7:0]      blue_out;
    logic [RowW-1:0] centre_row;
    logic [ColW-1:0] centre_column;
    logic            last_of_run;
    logic            frame_done;
  } res_t;

  // Input beat
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  // Root unit handshake
  typedef struct packed {
    logic start;
    logic busy;
  } root_ctl_t;

endpackage

>>> rtl/core/sem_if.sv
// ----------------------------------------------------------------------------
// Sobel stream interfaces
// Valid/ready channels for pixel and result beats.
// ----------------------------------------------------------------------------
interface sem_pix_if;
  logic           valid;
  logic           ready;
  sem_pkg::pix_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sem_res_if;
  logic           valid;
  logic           ready;
  sem_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/sobel_edge_magnitude_rgb_core.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude core
// ----------------------------------------------------------------------------
// Takes RGB pixels in raster order and returns per-channel rounded Sobel
// magnitudes, 0 to 4 result beats per pixel. Three rows live in one
// synchronous line memory (3*MAX_WIDTH x 24). Each result reads its nine
// neighbors one per cycle from that single memory port, then runs a
// bit-serial root of eight bit steps and one rounding step. No new pixel
// is taken while the core works on the results of the last one. No
// clearing pass after reset. Configuration must be written only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sem_pkg::CfgAW-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CfgDW-1:0]  cfg_data_i,
  sem_pix_if.sink                    pix_in,
  sem_res_if.source                  res_out
);

  `include "sobel_edge_magnitude_rgb_core_macros.svh"

  localparam int unsigned Depth = 3 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);

  // Configuration
  logic [sem_pkg::WCfgW-1:0] wid_q;
  logic [sem_pkg::HCfgW-1:0] hgt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= sem_pkg::WCfgW'(1024);
      hgt_q <= sem_pkg::HCfgW'(768);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sem_pkg::RegWidth:  wid_q <= cfg_data_i[sem_pkg::WCfgW-1:0];
        sem_pkg::RegHeight: hgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [XW-1:0]             w_eff;
  logic [sem_pkg::RowW-1:0]  h_eff;
  always_comb begin
    if (wid_q == '0) w_eff = XW'(1);
    else if (32'(wid_q) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(wid_q);
    h_eff = (hgt_q == '0) ? sem_pkg::RowW'(1) : hgt_q;
  end

  // Line memory
  logic [sem_pkg::PixW-1:0] mem [Depth];
  logic [sem_pkg::PixW-1:0] rd_q;
  logic                     we;
  logic [AW-1:0]            wa, ra;
  logic [sem_pkg::PixW-1:0] wd;
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // Sequencer state
  sem_pkg::seq_state_e st_q, st_d;
  logic [sem_pkg::RowW-1:0] row_q, row_d;
  logic [XW-1:0]            col_q, col_d;
  logic [1:0]               rot_q, rot_d;
  logic [1:0]               cur_q, cur_d;   // job being worked
  logic [3:0]               tap_q, tap_d;   // neighbor fetch index 0..9
  logic [sem_pkg::RowW-1:0] er_q, er_d;     // row of the step's pixel
  logic [XW-1:0]            ec_q, ec_d;
  logic [1:0]               erot_q, erot_d;
  logic signed [11:0]       gx_q [3], gy_q [3];
  logic signed [11:0]       gx_d [3], gy_d [3];
  logic                     tv_q, tv_d;     // fetched tap in range
  logic [3:0]               tk_q, tk_d;     // tap index of fetched data
  sem_pkg::res_t            ob_q, ob_d;
  logic                     ov_q, ov_d;
  logic                     root_start, root_busy;
  logic [7:0]               rr, rg, rb;
  logic [20:0]              sq [3];

  // Clamp and pixel acceptance
  logic [sem_pkg::RowW-1:0] r_c;
  logic [XW-1:0]            c_c;
  logic                     acc;
  always_comb begin
    r_c = (row_q > h_eff - 1'b1) ? h_eff - 1'b1 : row_q;
    c_c = (col_q > w_eff - 1'b1) ? w_eff - 1'b1 : col_q;
  end
  assign pix_in.ready = (st_q == sem_pkg::StIdle);
  assign acc = pix_in.valid && pix_in.ready;

  // Job centre: 0 above/c-1, 1 above/w-1, 2 cur/c-1, 3 cur/w-1
  logic [sem_pkg::RowW-1:0] cy;
  logic [XW-1:0]            cx;
  logic [3:0]               jobs4;
  always_comb begin
    cy = (cur_q[1]) ? er_q : er_q - 1'b1;
    cx = (cur_q[0]) ? w_eff - 1'b1 : ec_q - 1'b1;
  end

  // Tap offsets within the 3x3 window
  logic [1:0] trow, tcol;
  always_comb begin
    case (tap_q)
      4'd0: begin trow = 2'd0; tcol = 2'd0; end
      4'd1: begin trow = 2'd0; tcol = 2'd1; end
      4'd2: begin trow = 2'd0; tcol = 2'd2; end
      4'd3: begin trow = 2'd1; tcol = 2'd0; end
      4'd4: begin trow = 2'd1; tcol = 2'd1; end
      4'd5: begin trow = 2'd1; tcol = 2'd2; end
      4'd6: begin trow = 2'd2; tcol = 2'd0; end
      4'd7: begin trow = 2'd2; tcol = 2'd1; end
      4'd8: begin trow = 2'd2; tcol = 2'd2; end
      default: begin trow = 2'd0; tcol = 2'd0; end
    endcase
  end

  // Tap address
  logic signed [17:0] ty;
  logic signed [XW:0] tx;
  logic               tin;
  logic [1:0]         dd, slot;
  always_comb begin
    ty = $signed({2'b0, cy}) + $signed(18'(trow)) - 18'sd1;
    tx = $signed({1'b0, cx}) + $signed((XW+1)'(tcol)) - $signed((XW+1)'(1));
    tin = (tap_q < 4'd9) && ty >= 0 && tx >= 0 &&
          ty < $signed({2'b0, h_eff}) && tx < $signed({1'b0, w_eff});
    dd = 2'(er_q - ty[15:0]);
    slot = (erot_q >= dd) ? erot_q - dd : erot_q + 2'd3 - dd;
    ra = AW'(32'(slot) * MAX_WIDTH + 32'(tx[XW-1:0]));
  end

  // Pending jobs bitmask (4 jobs)
  logic [3:0] jm_q, jm_d;
  assign jobs4 = jm_q;
  logic [1:0] nxt;
  always_comb begin
    nxt = 2'd0;
    for (int k = 3; k >= 0; k--) if (jobs4[k]) nxt = 2'(k);
  end

  logic row_end, last_row;
  assign row_end  = (c_c == w_eff - 1'b1);
  assign last_row = (r_c == h_eff - 1'b1);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      sem_pkg::StIdle: if (acc && jm_d != 4'd0) st_d = sem_pkg::StRead;
      sem_pkg::StRead: if (tap_q == 4'd9) st_d = sem_pkg::StCalc;
      sem_pkg::StCalc: st_d = sem_pkg::StRoot;
      sem_pkg::StRoot: if (!root_busy) st_d = sem_pkg::StOut;
      sem_pkg::StOut:  if (!ov_q) st_d = (jm_q != 4'd0) ? sem_pkg::StRead
                                                        : sem_pkg::StIdle;
      default: st_d = sem_pkg::StIdle;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic signed [11:0] p;
    logic signed [11:0] kx, ky;
    p = '0; kx = '0; ky = '0;
    row_d = row_q; col_d = col_q; rot_d = rot_q;
    cur_d = cur_q; tap_d = tap_q;
    er_d = er_q; ec_d = ec_q; erot_d = erot_q;
    tv_d = 1'b0; tk_d = tap_q; jm_d = jm_q;
    ob_d = ob_q; ov_d = ov_q;
    we = 1'b0; wa = '0; wd = '0;
    root_start = 1'b0;
    for (int k = 0; k < 3; k++) begin gx_d[k] = gx_q[k]; gy_d[k] = gy_q[k]; end
    if (ov_q && res_out.ready) ov_d = 1'b0;
    case (st_q)
      sem_pkg::StIdle: begin
        if (acc) begin
          we = 1'b1;
          wa = AW'(32'(rot_q) * MAX_WIDTH + 32'(c_c));
          wd = {pix_in.data.blue_in, pix_in.data.green_in, pix_in.data.red_in};
          er_d = r_c; ec_d = c_c; erot_d = rot_q;
          jm_d[0] = (r_c != '0) && (c_c != '0);
          jm_d[1] = (r_c != '0) && row_end;
          jm_d[2] = last_row && (c_c != '0);
          jm_d[3] = last_row && row_end;
          tap_d = 4'd0;
          cur_d = 2'd0;
          for (int k = 3; k >= 0; k--) if (jm_d[k]) cur_d = 2'(k);
          if (row_end) begin
            col_d = '0;
            if (last_row) begin row_d = '0; rot_d = 2'd0; end
            else begin
              row_d = r_c + 1'b1;
              rot_d = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
            end
          end else col_d = c_c + 1'b1;
          for (int k = 0; k < 3; k++) begin gx_d[k] = '0; gy_d[k] = '0; end
        end
      end
      sem_pkg::StRead: begin
        // Accumulate previous tap while the next one is read
        if (tv_q) begin
          for (int k = 0; k < 3; k++) begin
            p = 12'(rd_q[8*k +: 8]);
            case (tk_q)
              4'd0: begin kx = -12'sd1; ky = -12'sd1; end
              4'd1: begin kx = 12'sd0;  ky = -12'sd2; end
              4'd2: begin kx = 12'sd1;  ky = -12'sd1; end
              4'd3: begin kx = -12'sd2; ky = 12'sd0;  end
              4'd5: begin kx = 12'sd2;  ky = 12'sd0;  end
              4'd6: begin kx = -12'sd1; ky = 12'sd1;  end
              4'd7: begin kx = 12'sd0;  ky = 12'sd2;  end
              4'd8: begin kx = 12'sd1;  ky = 12'sd1;  end
              default: begin kx = 12'sd0; ky = 12'sd0; end
            endcase
            gx_d[k] = gx_q[k] + p * kx;
            gy_d[k] = gy_q[k] + p * ky;
          end
        end
        tv_d = tin;
        tk_d = tap_q;
        if (tap_q != 4'd9) tap_d = tap_q + 4'd1;
      end
      sem_pkg::StCalc: begin
        root_start = 1'b1;
        jm_d[cur_q] = 1'b0;
      end
      sem_pkg::StOut: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          ob_d.red_out = rr; ob_d.green_out = rg; ob_d.blue_out = rb;
          ob_d.centre_row = cy;
          ob_d.centre_column = sem_pkg::ColW'(cx);
          ob_d.last_of_run = (jm_q == 4'd0);
          ob_d.frame_done = (cy == h_eff - 1'b1) && (cx == w_eff - 1'b1);
          cur_d = nxt; tap_d = 4'd0;
          for (int k = 0; k < 3; k++) begin gx_d[k] = '0; gy_d[k] = '0; end
        end
      end
      default: ;
    endcase
  end

  // Channel energies, gradients sign-extended before squaring
  always_comb begin
    logic signed [21:0] gxe, gye;
    gxe = '0; gye = '0;
    for (int k = 0; k < 3; k++) begin
      gxe = 22'(gx_q[k]);
      gye = 22'(gy_q[k]);
      sq[k] = 21'(gxe * gxe + gye * gye);
    end
  end

  sem_root u_root (
    .clk_i, .rst_ni,
    .start_i(root_start),
    .sq_r_i(sq[0]), .sq_g_i(sq[1]), .sq_b_i(sq[2]),
    .busy_o(root_busy),
    .r_o(rr), .g_o(rg), .b_o(rb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sem_pkg::StIdle;
      row_q <= '0; col_q <= '0; rot_q <= '0;
      jm_q <= '0; ov_q <= 1'b0; tv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      row_q <= row_d; col_q <= col_d; rot_q <= rot_d;
      jm_q <= jm_d; ov_q <= ov_d; tv_q <= tv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; tap_q <= tap_d;
    er_q <= er_d; ec_q <= ec_d; erot_q <= erot_d; tk_q <= tk_d;
    ob_q <= ob_d;
    for (int k = 0; k < 3; k++) begin gx_q[k] <= gx_d[k]; gy_q[k] <= gy_d[k]; end
  end

  assign res_out.valid = ov_q;
  assign res_out.data  = ob_q;

  `SEM_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni,
                  st_q != sem_pkg::StIdle, !pix_in.ready, "pixel taken while busy")
  `SEM_ASSERT_NXT(a_root_runs, clk_i, rst_ni,
                  st_q == sem_pkg::StCalc, root_busy, "root did not start")
  `SEM_ASSERT_IMP(a_rot_range, clk_i, rst_ni, 1'b1, rot_q != 2'd3, "bad rotation")

endmodule

>>> rtl/core/sem_root.sv
// ----------------------------------------------------------------------------
// Sobel rounded root
// Bit-serial rounded square root of three channel energies, saturated.
// ----------------------------------------------------------------------------
module sem_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [20:0] sq_r_i,
  input  logic [20:0] sq_g_i,
  input  logic [20:0] sq_b_i,
  output logic        busy_o,
  output logic [7:0]  r_o,
  output logic [7:0]  g_o,
  output logic [7:0]  b_o
);

  logic [3:0]  step_q, step_d;
  logic [20:0] s_q [3];
  logic [8:0]  f_q [3];
  logic [8:0]  f_d [3];

  // One result bit per cycle, MSB first, plus one rounding step
  always_comb begin
    logic [8:0]  bitv;
    logic [8:0]  t;
    logic [18:0] sq;
    logic [18:0] thr;
    step_d = step_q;
    bitv = 9'd0;
    if (start_i) step_d = 4'd9;
    else if (step_q != 4'd0) step_d = step_q - 4'd1;
    if (step_q > 4'd1) bitv = 9'd1 << (step_q - 4'd2);
    for (int k = 0; k < 3; k++) begin
      f_d[k] = f_q[k];
      t = f_q[k] | bitv;
      sq = 19'(t) * 19'(t);
      thr = 19'(f_q[k]) * 19'(f_q[k]) + 19'(f_q[k]);
      if (start_i) f_d[k] = 9'd0;
      else if (step_q > 4'd1) begin
        if (21'(sq) <= s_q[k]) f_d[k] = t;
      end else if (step_q == 4'd1) begin
        if (s_q[k] > 21'd65280) f_d[k] = 9'd255;
        else if (s_q[k] > 21'(thr)) f_d[k] = f_q[k] + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= '0;
    else step_q <= step_d;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q[0] <= sq_r_i;
      s_q[1] <= sq_g_i;
      s_q[2] <= sq_b_i;
    end
    for (int k = 0; k < 3; k++) f_q[k] <= f_d[k];
  end

  assign busy_o = (step_q != 4'd0);
  assign r_o = (f_q[0] > 9'd255) ? 8'd255 : f_q[0][7:0];
  assign g_o = (f_q[1] > 9'd255) ? 8'd255 : f_q[1][7:0];
  assign b_o = (f_q[2] > 9'd255) ? 8'd255 : f_q[2][7:0];

endmodule

>>> verif/tb_sobel_edge_magnitude_rgb_core.sv
// ----------------------------------------------------------------------------
// Sobel edge core testbench
// Streams RGB frames through the core and compares each result beat with an
// in-bench Sobel magnitude predictor. Frame sizes are changed between frames.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxW       = 1024;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned SettleCyc  = 200;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [sem_pkg::CfgAW-1:0] cfg_idx_i;
  logic [sem_pkg::CfgDW-1:0] cfg_data_i;

  sem_pix_if pix ();
  sem_res_if res ();

  sobel_edge_magnitude_rgb_core #(.MAX_WIDTH(MaxW)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix),
    .res_out    (res)
  );

  // Predictor state: frame geometry, line memory, raster position
  sem_pkg::pix_t rows_mem [3*MaxW];
  int unsigned   frame_w, frame_h;
  int unsigned   row_pos, col_pos, slot_pos;
  sem_pkg::res_t pending_q [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned res_gap = 0;
  bit          quiet;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Channel ch of frame pixel (y,x); zero outside the frame or the window
  function automatic int chan_at(int y, int x, int ch, int w, int h);
    int d;
    int unsigned slot;
    sem_pkg::pix_t p;
    if (y < 0 || x < 0 || y >= h || x >= w) return 0;
    d = int'(row_pos) - y;
    if (d < 0 || d > 2) return 0;
    slot = (slot_pos + 3 - d) % 3;
    p = rows_mem[slot*MaxW + x];
    case (ch)
      0: return p.red_in;
      1: return p.green_in;
      default: return p.blue_in;
    endcase
  endfunction

  // Rounded integer square root, saturated at 255
  function automatic logic [7:0] round_sqrt(int unsigned s);
    int unsigned f, t, b;
    if (s > 65280) return 8'd255;
    f = 0;
    for (b = 128; b != 0; b >>= 1) begin
      t = f | b;
      if (t*t <= s) f = t;
    end
    if (s > f*f + f) f++;
    return (f > 255) ? 8'd255 : f[7:0];
  endfunction

  function automatic sem_pkg::res_t centre_result(int y, int x, int w, int h);
    sem_pkg::res_t r;
    int gx, gy, ch, i, j, p;
    logic [7:0] mag [3];
    for (ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          p = chan_at(y+i-1, x+j-1, ch, w, h);
          gx += p * (j - 1) * ((i == 1) ? 2 : 1);
          gy += p * (i - 1) * ((j == 1) ? 2 : 1);
        end
      end
      mag[ch] = round_sqrt(gx*gx + gy*gy);
    end
    r.red_out       = mag[0];
    r.green_out     = mag[1];
    r.blue_out      = mag[2];
    r.centre_row    = y[sem_pkg::RowW-1:0];
    r.centre_column = x[sem_pkg::ColW-1:0];
    r.last_of_run   = 1'b0;
    r.frame_done    = (y == h-1 && x == w-1);
    return r;
  endfunction

  // Store one pixel and queue the centres it completes
  task automatic predict_pixel(input sem_pkg::pix_t p);
    int unsigned w, h, r, c;
    bit row_end, last_row;
    sem_pkg::res_t run [$];
    w = (frame_w == 0) ? 1 : ((frame_w > MaxW) ? MaxW : frame_w);
    h = (frame_h == 0) ? 1 : frame_h;
    if (col_pos > w-1) col_pos = w-1;
    if (row_pos > h-1) row_pos = h-1;
    slot_pos = slot_pos % 3;
    r = row_pos;
    c = col_pos;
    rows_mem[slot_pos*MaxW + c] = p;
    row_end  = (c == w-1);
    last_row = (r == h-1);
    if (r >= 1) begin
      if (c >= 1) run.push_back(centre_result(r-1, c-1, w, h));
      if (row_end) run.push_back(centre_result(r-1, w-1, w, h));
    end
    if (last_row) begin
      if (c >= 1) run.push_back(centre_result(r, c-1, w, h));
      if (row_end) run.push_back(centre_result(r, w-1, w, h));
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[k]) pending_q.push_back(run[k]);
    if (row_end) begin
      col_pos = 0;
      if (last_row) begin
        row_pos  = 0;
        slot_pos = 0;
      end else begin
        row_pos  = r + 1;
        slot_pos = (slot_pos + 1) % 3;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Result side: random stall per beat, compare with oldest expectation
  always @(negedge clk_i) begin
    if (res_gap > 0) begin
      res.ready <= 1'b0;
      res_gap--;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sem_pkg::res_t got, want;
    if (rst_ni && res.valid && res.ready) begin
      got = res.data;
      res_gap = quiet ? 0 : $urandom_range(0, 9);
      if (pending_q.size() == 0) begin
        report("unexpected result beat, row", int'(got.centre_row), -1);
      end else begin
        want = pending_q.pop_front();
        if (got.red_out != want.red_out) report("red_out", got.red_out, want.red_out);
        if (got.green_out != want.green_out)
          report("green_out", got.green_out, want.green_out);
        if (got.blue_out != want.blue_out) report("blue_out", got.blue_out, want.blue_out);
        if (got.centre_row != want.centre_row)
          report("centre_row", got.centre_row, want.centre_row);
        if (got.centre_column != want.centre_column)
          report("centre_column", got.centre_column, want.centre_column);
        if (got.last_of_run != want.last_of_run)
          report("last_of_run", got.last_of_run, want.last_of_run);
        if (got.frame_done != want.frame_done)
          report("frame_done", got.frame_done, want.frame_done);
      end
    end
  end

  // Send one pixel beat; valid stays high into the next beat when no gap
  task automatic send_pixel(input sem_pkg::pix_t p);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      pix.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix.valid <= 1'b1;
    pix.data  <= p;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    predict_pixel(p);
  endtask

  // Wait until every expected beat is back, then let the core settle
  task automatic drain();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sem_pkg::CfgAW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[sem_pkg::CfgDW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sem_pkg::RegWidth) frame_w = val & 32'h7FF;
    else frame_h = val & 32'hFFFF;
  endtask

  function automatic sem_pkg::pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return sem_pkg::pix_t'(24'($urandom));
    endcase
  endfunction

  task automatic send_rows(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // Extremes of the pixel values, tiny frames and zero-size registers
  task automatic test_directed();
    sem_pkg::pix_t pat [12];
    pat = '{'0, '1, '0, '1, '1, '0, 24'hFF0000, 24'h00FF00,
            24'h0000FF, 24'h800180, '1, 24'h7F7F7F};
    write_reg(sem_pkg::RegWidth, 4);
    write_reg(sem_pkg::RegHeight, 3);
    foreach (pat[k]) send_pixel(pat[k]);
    drain();
    write_reg(sem_pkg::RegWidth, 1);
    write_reg(sem_pkg::RegHeight, 1);
    send_pixel('1);
    drain();
    write_reg(sem_pkg::RegWidth, 0);
    write_reg(sem_pkg::RegHeight, 0);
    send_pixel(24'hA5A5A5);
    drain();
    write_reg(sem_pkg::RegWidth, 2);
    write_reg(sem_pkg::RegHeight, 1);
    send_pixel('1);
    send_pixel('0);
    drain();
  endtask

  // Random small frames; idling on or off per frame
  task automatic test_random_frames();
    int unsigned sent, w, h;
    sent = 0;
    while (sent < 120) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(sem_pkg::RegWidth, w);
      write_reg(sem_pkg::RegHeight, h);
      send_rows(((w == 0) ? 1 : w) * ((h == 0) ? 1 : h));
      sent += ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      drain();
    end
    quiet = 1'b0;
  endtask

  // Tallest frame: a few rows, then the height is lowered to close it
  task automatic test_tall_frame();
    write_reg(sem_pkg::RegWidth, 4);
    write_reg(sem_pkg::RegHeight, 65535);
    send_rows(16);
    drain();
    write_reg(sem_pkg::RegHeight, 6);
    send_rows(8);
    drain();
  endtask

  initial begin
    quiet      = 1'b0;
    frame_w    = 1024;
    frame_h    = 768;
    row_pos    = 0;
    col_pos    = 0;
    slot_pos   = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    pix.valid  = 1'b0;
    pix.data   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_frames();
    test_tall_frame();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
